// ===== rtl/core/rfaf_pkg.sv =====
// ----------------------------------------------------------------------------
// rfaf_pkg
// Shared types, constants and the CRC-16 byte update for the frame
// acceptance filter.
// ----------------------------------------------------------------------------
package rfaf_pkg;

    // Width of the saturating frame byte counter (9 to 16)
    localparam int COUNT_WIDTH = 10;

    // Result field widths
    localparam int VERDICT_W = 3;
    localparam int PDU_W     = 10;

    // Reflected CRC-16
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Longest PDU length reported
    localparam int PDU_MAX = 1020;

    // Reset value of the station address register
    localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;

    // Broadcast station address
    localparam logic [7:0] ADDR_BROADCAST = 8'h00;

    // Function codes treated as writes on a broadcast
    localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
    localparam logic [7:0] FC_WRITE_REG       = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI_COIL = 8'h0F;
    localparam logic [7:0] FC_WRITE_MULTI_REG  = 8'h10;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_SHORT  = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_CRC_ERROR  = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_OTHER_ADDR = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_BCAST_READ = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_BCAST_WRITE = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_UNICAST    = 3'd5;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Item held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } rfaf_item_t;

    // One byte through the reflected CRC-16, LSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Function codes that modify data
    function automatic logic is_write_fc(input logic [7:0] fc);
        return (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG) ||
               (fc == FC_WRITE_MULTI_COIL) || (fc == FC_WRITE_MULTI_REG);
    endfunction

endpackage

// ===== rtl/core/rfaf_channels.sv =====
// ----------------------------------------------------------------------------
// rfaf_channels
// Valid/ready channels of the frame acceptance filter: received bytes,
// verdicts and the station address write.
// ----------------------------------------------------------------------------

// Received byte stream
interface rfaf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// Verdict stream
interface rfaf_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [7:0]  function_code;
    logic [9:0]  pdu_length;

    modport source (output valid, output verdict, output function_code,
                    output pdu_length, input ready);
    modport sink   (input valid, input verdict, input function_code,
                    input pdu_length, output ready);
endinterface

// Station address write
interface rfaf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] slave_address;

    modport source (output valid, output slave_address, input ready);
    modport sink   (input valid, input slave_address, output ready);
endinterface

// ===== rtl/core/rfaf_input_stage.sv =====
// ----------------------------------------------------------------------------
// rfaf_input_stage
// Input register for received bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module rfaf_input_stage
    import rfaf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rfaf_rx_if.sink    rx,
    input  logic       take,
    output rfaf_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       rx_xfer;

    // free when empty or being drained
    assign rx.ready = !valid_reg || take;
    assign rx_xfer  = rx.valid && rx.ready;

    always_comb
    begin
        if (rx_xfer)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture on each transfer
    always_ff @(posedge clk)
    begin
        if (rx_xfer)
        begin
            data_reg <= rx.rx_byte;
            last_reg <= rx.last_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.last  = last_reg;

endmodule

// ===== rtl/core/rfaf_frame_check.sv =====
// ----------------------------------------------------------------------------
// rfaf_frame_check
// Frame state (CRC, delay line, counter, captured header) and the verdict
// result register.
// ----------------------------------------------------------------------------
module rfaf_frame_check
    import rfaf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rfaf_item_t    item,
    input  logic [7:0]    slave_address,
    output logic          take,
    rfaf_result_if.source result
);

    localparam int PW = COUNT_WIDTH + 1;
    localparam logic [PW-1:0] PDU_MAX_X = PW'(PDU_MAX);

    logic [15:0]    crc_reg,  crc_next;
    logic [7:0]     dly0_reg, dly0_next;
    logic [7:0]     dly1_reg, dly1_next;
    count_t         count_reg, count_next;
    logic [7:0]     addr_reg, addr_next;
    logic [7:0]     func_reg, func_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [7:0]           fc_out_reg;
    logic [PDU_W-1:0]     pdu_reg;

    logic                 out_free;
    logic [15:0]          crc_upd;
    logic [7:0]           addr_cur;
    logic [7:0]           func_cur;
    count_t               len;
    logic [15:0]          recv_crc;
    logic [PW-1:0]        pdu_wide;
    logic [PW-1:0]        pdu_sat;
    logic [VERDICT_W-1:0] verdict;

    // a last byte waits for room in the result register
    assign out_free = !out_valid_reg || result.ready;
    assign take     = item.valid && (!item.last || out_free);

    // per-byte datapath
    always_comb
    begin
        crc_upd  = (count_reg >= COUNT_WIDTH'(2)) ? crc16_feed(crc_reg, dly1_reg) : crc_reg;
        addr_cur = (count_reg == '0) ? item.data : addr_reg;
        func_cur = (count_reg == COUNT_WIDTH'(1)) ? item.data : func_reg;
        len      = (count_reg != '1) ? count_reg + COUNT_WIDTH'(1) : count_reg;
        recv_crc = {item.data, dly0_reg};
        pdu_wide = {1'b0, len} - PW'(3);
        pdu_sat  = (pdu_wide > PDU_MAX_X) ? PDU_MAX_X : pdu_wide;
    end

    // verdict decision
    always_comb
    begin
        if (len < COUNT_WIDTH'(4))
            verdict = VERDICT_TOO_SHORT;
        else if (recv_crc != crc_upd)
            verdict = VERDICT_CRC_ERROR;
        else if (addr_cur == ADDR_BROADCAST)
            verdict = is_write_fc(func_cur) ? VERDICT_BCAST_WRITE : VERDICT_BCAST_READ;
        else if (addr_cur != slave_address)
            verdict = VERDICT_OTHER_ADDR;
        else
            verdict = VERDICT_UNICAST;
    end

    // frame state update; back to start of frame after the last byte
    always_comb
    begin
        crc_next   = crc_reg;
        dly0_next  = dly0_reg;
        dly1_next  = dly1_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        func_next  = func_reg;
        if (take)
        begin
            if (item.last)
            begin
                crc_next   = CRC_INIT;
                dly0_next  = 8'h00;
                dly1_next  = 8'h00;
                count_next = '0;
                addr_next  = 8'h00;
                func_next  = 8'h00;
            end
            else
            begin
                crc_next   = crc_upd;
                dly0_next  = item.data;
                dly1_next  = dly0_reg;
                count_next = len;
                addr_next  = addr_cur;
                func_next  = func_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            dly0_reg  <= 8'h00;
            dly1_reg  <= 8'h00;
            count_reg <= '0;
            addr_reg  <= 8'h00;
            func_reg  <= 8'h00;
        end
        else
        begin
            crc_reg   <= crc_next;
            dly0_reg  <= dly0_next;
            dly1_reg  <= dly1_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
        end
    end

    // result register
    always_comb
    begin
        if (take && item.last)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && item.last)
        begin
            verdict_reg <= verdict;
            fc_out_reg  <= func_cur;
            pdu_reg     <= (verdict == VERDICT_TOO_SHORT) ? '0 : pdu_sat[PDU_W-1:0];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.verdict       = verdict_reg;
    assign result.function_code = fc_out_reg;
    assign result.pdu_length    = pdu_reg;

endmodule

// ===== rtl/core/rtu_frame_acceptance_filter.sv =====
// ----------------------------------------------------------------------------
// rtu_frame_acceptance_filter
// Checks received serial slave frames (CRC-16, address, broadcast function)
// and gives one verdict per frame with the function code and PDU length.
//
//   Channel  Role  Carries
//   rx       sink  rx_byte, last_byte       one frame byte per transfer
//   result   src   verdict, function_code,  one per frame, on its last byte
//                  pdu_length
//   cfg      sink  slave_address            station address, reset 1
//
// One byte per cycle, but a last byte waits while the result register is full;
// each byte is registered in the input register, and a frame's verdict is
// registered in the result register as the input register hands on its last byte.
// Reset returns the frame state to start of frame and the address to 1.
// The result register holds while result.ready is low; only a last byte
// stalls behind it, other bytes keep flowing. cfg is always ready.
// ----------------------------------------------------------------------------
module rtu_frame_acceptance_filter
    import rfaf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rfaf_rx_if.sink       rx,
    rfaf_result_if.source result,
    rfaf_cfg_if.sink      cfg
);

    rfaf_item_t item;
    logic       take;
    logic [7:0] slave_address_reg;

    // station address register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_address_reg <= SLAVE_ADDR_RESET;
        else if (cfg.valid && cfg.ready)
            slave_address_reg <= cfg.slave_address;
    end

    rfaf_input_stage u_input_stage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .item  (item)
    );

    rfaf_frame_check u_frame_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .slave_address (slave_address_reg),
        .take          (take),
        .result        (result)
    );

endmodule
